// ----- rtl/sync_framed_flow_averager_macros.svh -----
// assertion macros for the flow averager
// expects clk and arst_n in the scope of each use
`ifndef SYNC_FRAMED_FLOW_AVERAGER_MACROS_SVH
`define SYNC_FRAMED_FLOW_AVERAGER_MACROS_SVH

// same-cycle implication, off during reset
`define SFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define SFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sfa_pkg.sv -----
// shared constants and control structs for the flow averager
// no dependencies
`default_nettype none

package sfa_pkg;

	localparam int WINDOW_BYTES  = 4;
	localparam int FACTOR_BITS   = 7;
	localparam int RATE_BITS     = 20;
	localparam int SUM_BITS      = 32;
	// |sum| * 10 stays below 2^35
	localparam int DIVIDEND_BITS = 35;

	localparam logic [7:0]           SYNC_MARK    = 8'h7F;
	localparam logic [RATE_BITS-1:0] RATE_MAX     = 20'd327670;
	localparam logic [RATE_BITS-1:0] RATE_MIN_MAG = 20'd327680;

	typedef struct packed {
		logic accept;
		logic clear;
	} frame_ctrl_t;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ----- rtl/sfa_byte_if.sv -----
// byte channel and rate channel of the flow averager
// depends on nothing but the clock-free handshake signals
`default_nettype none

interface sfa_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       batch_last;

	modport source (output valid, output data_byte, output batch_last, input ready);
	modport sink (input valid, input data_byte, input batch_last, output ready);
endinterface

interface sfa_rate_if;
	logic               valid;
	logic               ready;
	logic signed [19:0] flow_tenths;
	logic               has_reading;
	logic [15:0]        frame_count;

	modport source (output valid, output flow_tenths, output has_reading,
		output frame_count, input ready);
	modport sink (input valid, input flow_tenths, input has_reading,
		input frame_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/sfa_frame.sv -----
// sync window, frame detect and saturating reading accumulator
// uses sfa_pkg
`default_nettype none

module sfa_frame
	import sfa_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  frame_ctrl_t                ctrl,
	input  wire  [7:0]                 data_byte,
	output logic signed [SUM_BITS-1:0] sum,
	output logic [COUNT_BITS-1:0]      count
);

	logic [7:0]                win_q [WINDOW_BYTES-1];
	logic signed [SUM_BITS-1:0] sum_q;
	logic [COUNT_BITS-1:0]     count_q;

	logic                      hit;
	logic signed [15:0]        reading;
	logic signed [SUM_BITS:0]  sum_wide;
	logic signed [SUM_BITS-1:0] sum_sat;

	assign hit = (win_q[0] == SYNC_MARK) && (win_q[1] == SYNC_MARK)
		&& (win_q[2] != SYNC_MARK);
	assign reading = {win_q[2], data_byte};

	always_comb begin
		sum_wide = {sum_q[SUM_BITS-1], sum_q} + (SUM_BITS+1)'(reading);
		if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
			sum_sat = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
				: {1'b0, {(SUM_BITS-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[SUM_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_BYTES - 1; i++) win_q[i] <= 8'h00;
			sum_q   <= '0;
			count_q <= '0;
		end else if (ctrl.clear) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (ctrl.accept) begin
			for (int i = 0; i < WINDOW_BYTES - 2; i++) win_q[i] <= win_q[i+1];
			win_q[WINDOW_BYTES-2] <= data_byte;
			if (hit) begin
				sum_q <= sum_sat;
				if (count_q != {COUNT_BITS{1'b1}}) count_q <= count_q + 1'b1;
			end
		end
	end

	assign sum   = sum_q;
	assign count = count_q;

endmodule

`default_nettype wire

// ----- rtl/sfa_div.sv -----
// shared restoring divider, one quotient bit per cycle
// uses sfa_pkg; forms dividend*10 on load
`default_nettype none

module sfa_div
	import sfa_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  div_ctrl_t                        ctrl,
	input  wire  [SUM_BITS-1:0]              magnitude,
	input  wire  [FACTOR_BITS+COUNT_BITS-1:0] divisor,
	output div_stat_t                        stat,
	output logic [DIVIDEND_BITS-1:0]         quotient
);

	localparam int DW   = FACTOR_BITS + COUNT_BITS;
	localparam int NW   = DIVIDEND_BITS;
	localparam int CntW = $clog2(NW + 1);

	logic [DW-1:0]   div_q;
	logic [DW-1:0]   rem_q;
	logic [NW-1:0]   quo_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [NW-1:0]   mag_ext;
	logic [NW-1:0]   times_ten;
	logic [DW:0]     trial;
	logic            fits;
	logic [DW:0]     rem_nx;

	assign mag_ext   = NW'(magnitude);
	assign times_ten = (mag_ext << 3) + (mag_ext << 1);

	assign trial  = {rem_q, quo_q[NW-1]};
	assign fits   = trial >= {1'b0, div_q};
	assign rem_nx = fits ? trial - {1'b0, div_q} : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CntW'(NW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= times_ten;
		end else if (busy_q) begin
			rem_q <= rem_nx[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

`default_nettype wire

// ----- rtl/sync_framed_flow_averager.sv -----
// top level: byte sequencer around the frame accumulator and shared divider
// uses sfa_pkg, sfa_byte_if, sfa_rate_if, sfa_frame, sfa_div and the macro header
//
//  channel   dir   payload                                  handshake
//  bytes     in    data_byte[7:0], batch_last                valid/ready
//  rate      out   flow_tenths[19:0] s, has_reading,         valid/ready
//                  frame_count[15:0]
//  cfg       in    cfg_wdata[6:0] (flow_factor)              cfg_we, no ready
//
// a byte without batch_last is taken as it comes; a batch-end byte holds the input
// through accept, prep, start, the divider steps, done and emit
// a batch with no frame skips the divider and goes through accept, prep, emit
// reset clears window, sum, count and held rate; flow_factor resets to 1
// a finished word sits in the output register while new bytes are taken
// if that register is still full, the sequencer waits before the next result
`default_nettype none
`include "sync_framed_flow_averager_macros.svh"

module sync_framed_flow_averager
	import sfa_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	sfa_byte_if.sink              bytes,
	sfa_rate_if.source            rate,
	input  wire                   cfg_we,
	input  wire [FACTOR_BITS-1:0] cfg_wdata
);

	localparam int DW   = FACTOR_BITS + COUNT_BITS;
	localparam int ExtW = COUNT_BITS > 16 ? COUNT_BITS : 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_START,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	state_t state_q;

	// configuration
	logic [FACTOR_BITS-1:0] factor_q;

	// frame accumulator
	frame_ctrl_t                frame_ctrl;
	logic signed [SUM_BITS-1:0] sum;
	logic [COUNT_BITS-1:0]      count;

	// divider
	div_ctrl_t                  div_ctrl;
	div_stat_t                  div_stat;
	logic [DIVIDEND_BITS-1:0]   quotient;

	// operands and result holding
	logic [SUM_BITS-1:0]        mag_q;
	logic                       neg_q;
	logic [DW-1:0]              divisor_q;
	logic                       has_q;
	logic [15:0]                shown_q;
	logic signed [RATE_BITS-1:0] held_rate_q;

	// output register
	logic                       out_valid_q;
	logic signed [RATE_BITS-1:0] out_rate_q;
	logic                       out_has_q;
	logic [15:0]                out_count_q;

	logic                       in_accept;
	logic [FACTOR_BITS-1:0]     factor_eff;
	logic [ExtW-1:0]            count_ext;
	logic [15:0]                shown;
	logic [SUM_BITS-1:0]        sum_mag;
	logic [RATE_BITS-1:0]       q_low;
	logic signed [RATE_BITS-1:0] rate_sat;
	logic                       slot_free;

	assign in_accept = bytes.valid && bytes.ready;
	assign bytes.ready = (state_q == ST_IDLE);

	// zero factor behaves as one
	assign factor_eff = (factor_q == '0) ? FACTOR_BITS'(1) : factor_q;

	// frame count shown on the port caps at 16 bits
	assign count_ext = ExtW'(count);
	assign shown = (count_ext > ExtW'(17'h0FFFF)) ? 16'hFFFF : count_ext[15:0];

	// magnitude of the sum, most negative value included
	assign sum_mag = sum[SUM_BITS-1] ? (~sum + 1'b1) : sum;

	// saturate the divider result to the rate range, truncation toward zero
	assign q_low = quotient[RATE_BITS-1:0];
	always_comb begin
		if (neg_q) begin
			rate_sat = (quotient > DIVIDEND_BITS'(RATE_MIN_MAG)) ? -RATE_MIN_MAG : -q_low;
		end else begin
			rate_sat = (quotient > DIVIDEND_BITS'(RATE_MAX)) ? RATE_MAX : q_low;
		end
	end

	assign frame_ctrl.accept = in_accept;
	assign frame_ctrl.clear  = (state_q == ST_PREP);
	assign div_ctrl.start    = (state_q == ST_START);

	assign slot_free = !out_valid_q || rate.ready;

	sfa_frame #(
		.COUNT_BITS(COUNT_BITS)
	) u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (frame_ctrl),
		.data_byte(bytes.data_byte),
		.sum      (sum),
		.count    (count)
	);

	sfa_div #(
		.COUNT_BITS(COUNT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.magnitude(mag_q),
		.divisor  (divisor_q),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// flow factor register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_BITS'(1);
		end else if (cfg_we) begin
			factor_q <= cfg_wdata;
		end
	end

	// sequencer with its registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_rate_q <= '0;
			has_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a new word replaces the one leaving in the same cycle
			if (state_q == ST_EMIT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (rate.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && bytes.batch_last) state_q <= ST_PREP;
				end
				ST_PREP: begin
					// sum and count already include the batch-end byte
					has_q   <= (count != '0);
					state_q <= (count != '0) ? ST_START : ST_EMIT;
				end
				ST_START: begin
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (div_stat.done) begin
						held_rate_q <= rate_sat;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// operand and output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			mag_q     <= sum_mag;
			neg_q     <= sum[SUM_BITS-1];
			divisor_q <= DW'(factor_eff * count);
			shown_q   <= shown;
		end
		if (state_q == ST_EMIT && slot_free) begin
			out_rate_q  <= held_rate_q;
			out_has_q   <= has_q;
			out_count_q <= shown_q;
		end
	end

	assign rate.valid       = out_valid_q;
	assign rate.flow_tenths = out_rate_q;
	assign rate.has_reading = out_has_q;
	assign rate.frame_count = out_count_q;

	`SFA_ASSERT_NEXT(a_last_starts_prep, in_accept && bytes.batch_last, state_q == ST_PREP, "batch end did not start a result")
	`SFA_ASSERT_NOW(a_done_only_dividing, div_stat.done, state_q == ST_DIVIDE, "divider finished outside divide step")
	`SFA_ASSERT_NOW(a_busy_only_dividing, div_stat.busy, state_q == ST_DIVIDE, "divider busy outside divide step")
	`SFA_ASSERT_NOW(a_empty_batch_zero, rate.valid && !rate.has_reading, rate.frame_count == 16'd0, "empty batch with nonzero count")
	`SFA_ASSERT_NOW(a_rate_in_range, rate.valid && rate.has_reading, (rate.flow_tenths <= $signed(RATE_MAX)) && (rate.flow_tenths >= -$signed(RATE_MIN_MAG)), "rate out of range")

endmodule

`default_nettype wire
